/* rtl/mfpu_pkg.sv */
// Shared types and constants for the minifloat pack/unpack converter.
// Used by mfpu_pack, mfpu_unpack and minifloat_pack_unpack_top; no dependencies.
package mfpu_pkg;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned EXP_CFG_W  = 4;
  localparam int unsigned MANT_CFG_W = 5;
  localparam int unsigned CFG_DATA_W = 5;
  localparam int unsigned CFG_IDX_W  = 1;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_EXP_BITS  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MANT_BITS = 1'd1;

  // Request kinds carried in tuser
  localparam logic REQ_PACK   = 1'b0;
  localparam logic REQ_UNPACK = 1'b1;

  // Reset values and legal limits of the format registers
  localparam logic [EXP_CFG_W-1:0]  EXP_BITS_RST  = 4'd5;
  localparam logic [EXP_CFG_W-1:0]  EXP_BITS_MIN  = 4'd2;
  localparam logic [EXP_CFG_W-1:0]  EXP_BITS_MAX  = 4'd8;
  localparam logic [MANT_CFG_W-1:0] MANT_BITS_RST = 5'd10;
  localparam logic [MANT_CFG_W-1:0] MANT_BITS_MIN = 5'd2;
  localparam logic [MANT_CFG_W-1:0] MANT_BITS_MAX = 5'd23;

  // Small-format geometry after saturation into the legal ranges
  typedef struct packed {
    logic [EXP_CFG_W-1:0]  eb;  // exponent field width incl. its sign bit, 2..8
    logic [MANT_CFG_W-1:0] mb;  // mantissa field width, 2..23
  } fmt_t;

endpackage

/* rtl/minifloat_pack_unpack_top.sv */
// Minifloat pack/unpack converter, top level.
// An accepted input beat passes the input register, then the result register, to out_tvalid.
// One beat per cycle while out_tready is high; the result register refills if empty or taken.
// Reset (rst_n low, synchronous): both pipeline valids clear, exponent_bits = 5,
// mantissa_bits = 10. Depends on mfpu_pkg, mfpu_pack, mfpu_unpack.
module minifloat_pack_unpack_top (
  input  logic                                clk,
  input  logic                                rst_n,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [mfpu_pkg::DATA_W-1:0]         in_tdata,   // [31:0] operand_value
  input  logic                                in_tuser,   // [0] req_type
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [mfpu_pkg::DATA_W-1:0]         out_tdata,  // [31:0] result_value
  // configuration write port
  input  logic                                cfg_wr_en,
  input  logic [mfpu_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mfpu_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  // format registers, raw as written
  logic [mfpu_pkg::EXP_CFG_W-1:0]  exp_bits_r;
  logic [mfpu_pkg::MANT_CFG_W-1:0] mant_bits_r;
  mfpu_pkg::fmt_t                  fmt;

  // input stage
  logic                            s1_v_r;
  logic [mfpu_pkg::DATA_W-1:0]     s1_op_r;
  logic                            s1_kind_r;

  // result stage
  logic                            out_v_r;
  logic [mfpu_pkg::DATA_W-1:0]     out_data_r;
  logic                            out_kind_r;

  logic                            adv;
  logic [mfpu_pkg::DATA_W-1:0]     pack_res;
  logic [mfpu_pkg::DATA_W-1:0]     unpack_res;
  logic [mfpu_pkg::DATA_W-1:0]     res_nxt;

  // Saturate the format registers into their legal ranges before use.
  always_comb begin
    priority if (exp_bits_r < mfpu_pkg::EXP_BITS_MIN) begin
      fmt.eb = mfpu_pkg::EXP_BITS_MIN;
    end else if (exp_bits_r > mfpu_pkg::EXP_BITS_MAX) begin
      fmt.eb = mfpu_pkg::EXP_BITS_MAX;
    end else begin
      fmt.eb = exp_bits_r;
    end
    priority if (mant_bits_r < mfpu_pkg::MANT_BITS_MIN) begin
      fmt.mb = mfpu_pkg::MANT_BITS_MIN;
    end else if (mant_bits_r > mfpu_pkg::MANT_BITS_MAX) begin
      fmt.mb = mfpu_pkg::MANT_BITS_MAX;
    end else begin
      fmt.mb = mant_bits_r;
    end
  end

  // Advance the result register when it is empty or its beat is taken;
  // the input register refills whenever it is empty or moves forward.
  assign adv        = !out_v_r || out_tready;
  assign in_tready  = !s1_v_r || adv;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  mfpu_pack u_pack (
    .fmt     (fmt),
    .operand (s1_op_r),
    .result  (pack_res)
  );

  mfpu_unpack u_unpack (
    .fmt     (fmt),
    .operand (s1_op_r),
    .result  (unpack_res)
  );

  // Select the converter that matches the request kind.
  always_comb begin
    unique case (s1_kind_r)
      mfpu_pkg::REQ_PACK:   res_nxt = pack_res;
      mfpu_pkg::REQ_UNPACK: res_nxt = unpack_res;
      default:              res_nxt = pack_res;
    endcase
  end

  // Control state and format registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      out_v_r     <= 1'b0;
      exp_bits_r  <= mfpu_pkg::EXP_BITS_RST;
      mant_bits_r <= mfpu_pkg::MANT_BITS_RST;
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == mfpu_pkg::REG_EXP_BITS) begin
          exp_bits_r <= cfg_wdata[mfpu_pkg::EXP_CFG_W-1:0];
        end else begin
          mant_bits_r <= cfg_wdata[mfpu_pkg::MANT_CFG_W-1:0];
        end
      end
      if (in_tready) begin
        s1_v_r <= in_tvalid;
      end
      if (adv) begin
        out_v_r <= s1_v_r;
      end
    end
  end

  // Payload registers: load on an accepted beat, hold otherwise.
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_op_r   <= in_tdata;
      s1_kind_r <= in_tuser;
    end
    if (adv && s1_v_r) begin
      out_data_r <= res_nxt;
      out_kind_r <= s1_kind_r;
    end
  end

`ifndef NO_ASSERTIONS
  // An item waiting in the input register moves forward when the result register is empty.
  a_s1_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !out_v_r) |=> out_v_r)
    else $error("input stage item did not advance into empty result register");

  // The input side never stalls while the result register is empty.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_v_r |-> in_tready)
    else $error("in_tready low with empty result register");

  // A packed result never has bits above the small-format sign bit.
  a_pack_width: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && (out_kind_r == mfpu_pkg::REQ_PACK))
      |-> ((out_data_r >> (5'(fmt.eb) + fmt.mb + 6'd1)) == 32'd0))
    else $error("packed result wider than configured format");
`endif

endmodule

/* rtl/mfpu_pack.sv */
// IEEE single to small-format packer with min/max clamp; combinational.
// Depends on mfpu_pkg (fmt_t).
module mfpu_pack (
  input  mfpu_pkg::fmt_t fmt,
  input  logic [31:0]    operand,
  output logic [31:0]    result
);

  logic [2:0]  mag_w;
  logic [4:0]  top_sh;
  logic [4:0]  mant_sh;
  logic [31:0] mag_mask;
  logic [31:0] mb_mask;
  logic [31:0] sbit;
  logic [31:0] max_pat;
  logic [31:0] min_pat;
  logic [31:0] sgn;
  logic [7:0]  max_b;
  logic [7:0]  min_b;
  logic [22:0] max_m;
  logic [22:0] min_m;
  logic [30:0] max_ieee;
  logic [30:0] min_ieee;
  logic [30:0] fmag;
  logic        is_nan;
  logic        neg;
  logic [7:0]  biased;
  logic [7:0]  dmag;
  logic        negx;
  logic [31:0] field_exp;
  logic [31:0] plain;

  always_comb begin
    mag_w    = 3'(fmt.eb - 4'd1);
    top_sh   = 5'(fmt.eb) + fmt.mb;
    mant_sh  = 5'd23 - fmt.mb;
    mag_mask = ~(32'hFFFF_FFFF << mag_w);
    mb_mask  = ~(32'hFFFF_FFFF << fmt.mb);
    sbit     = 32'h1 << top_sh;

    // largest pattern: top positive exponent, all-ones mantissa
    max_pat  = (mag_mask << fmt.mb) | mb_mask;
    // smallest pattern: most negative usable exponent, mantissa one
    min_pat  = (((32'h1 << fmt.eb) - 32'd2) << fmt.mb) | 32'h1;

    // IEEE magnitudes of the clamp bounds
    max_b    = 8'd127 + {1'b0, mag_mask[6:0]};
    min_b    = 8'd129 - (8'd1 << mag_w);
    max_m    = 23'(mb_mask << mant_sh);
    min_m    = 23'(32'h1 << mant_sh);
    max_ieee = {max_b, max_m};
    min_ieee = {min_b, min_m};

    fmag     = operand[30:0];
    is_nan   = fmag > 31'h7F80_0000;
    neg      = operand[31] && (fmag != 31'd0);
    sgn      = neg ? sbit : 32'd0;

    // plain conversion: sign-magnitude unbiased exponent, truncated mantissa
    biased    = operand[30:23];
    negx      = biased < 8'd127;
    dmag      = negx ? (8'd127 - biased) : (biased - 8'd127);
    field_exp = (32'(negx) << mag_w) | ({24'd0, dmag} & mag_mask);
    plain     = (32'(operand[31]) << top_sh) | (field_exp << fmt.mb)
              | ({9'd0, operand[22:0]} >> mant_sh);

    priority if (!is_nan && (fmag >= max_ieee)) begin
      result = max_pat | sgn;
    end else if (!is_nan && (fmag <= min_ieee)) begin
      result = min_pat | sgn;
    end else begin
      result = plain;
    end
  end

endmodule

/* rtl/mfpu_unpack.sv */
// Small-format to IEEE single unpacker, re-biasing the exponent by 127; combinational.
// Depends on mfpu_pkg (fmt_t).
module mfpu_unpack (
  input  mfpu_pkg::fmt_t fmt,
  input  logic [31:0]    operand,
  output logic [31:0]    result
);

  logic [2:0]  mag_w;
  logic [4:0]  top_sh;
  logic [4:0]  neg_sh;
  logic [4:0]  mant_sh;
  logic [31:0] mag_mask;
  logic [31:0] mb_mask;
  logic        sign;
  logic        neg;
  logic [6:0]  mag;
  logic [7:0]  biased;
  logic [22:0] mant;

  always_comb begin
    mag_w    = 3'(fmt.eb - 4'd1);
    top_sh   = 5'(fmt.eb) + fmt.mb;
    neg_sh   = 5'(mag_w) + fmt.mb;
    mant_sh  = 5'd23 - fmt.mb;
    mag_mask = ~(32'hFFFF_FFFF << mag_w);
    mb_mask  = ~(32'hFFFF_FFFF << fmt.mb);

    // bits above the small sign bit are ignored
    sign   = operand[top_sh];
    neg    = operand[neg_sh];
    mag    = 7'((operand >> fmt.mb) & mag_mask);
    biased = neg ? (8'd127 - {1'b0, mag}) : (8'd127 + {1'b0, mag});
    mant   = 23'((operand & mb_mask) << mant_sh);
    result = {sign, biased, mant};
  end

endmodule

/* verif/minifloat_pack_unpack_top_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for minifloat_pack_unpack_top: random stream traffic on both sides,
// format changes between phases, results checked against an in-bench converter model.
// Depends on mfpu_pkg and the converter RTL.

typedef struct {
  logic        req;
  logic [31:0] operand;
  logic [31:0] result;
} conv_expect_t;

// Tracks the format registers, predicts each conversion and matches result beats in order.
class minifloat_checker;
  logic [mfpu_pkg::EXP_CFG_W-1:0]  exp_bits;
  logic [mfpu_pkg::MANT_CFG_W-1:0] mant_bits;
  conv_expect_t                    pending_results[$];
  int unsigned                     failures;

  function new();
    exp_bits  = mfpu_pkg::EXP_BITS_RST;
    mant_bits = mfpu_pkg::MANT_BITS_RST;
    failures  = 0;
  endfunction

  function void write_reg(logic [mfpu_pkg::CFG_IDX_W-1:0] idx,
                          logic [mfpu_pkg::CFG_DATA_W-1:0] data);
    if (idx == mfpu_pkg::REG_EXP_BITS) exp_bits = data[mfpu_pkg::EXP_CFG_W-1:0];
    else if (idx == mfpu_pkg::REG_MANT_BITS) mant_bits = data[mfpu_pkg::MANT_CFG_W-1:0];
  endfunction

  // Out-of-range register values saturate into the legal widths when used
  function int unsigned eff_exp();
    if (exp_bits < mfpu_pkg::EXP_BITS_MIN) return mfpu_pkg::EXP_BITS_MIN;
    if (exp_bits > mfpu_pkg::EXP_BITS_MAX) return mfpu_pkg::EXP_BITS_MAX;
    return exp_bits;
  endfunction

  function int unsigned eff_mant();
    if (mant_bits < mfpu_pkg::MANT_BITS_MIN) return mfpu_pkg::MANT_BITS_MIN;
    if (mant_bits > mfpu_pkg::MANT_BITS_MAX) return mfpu_pkg::MANT_BITS_MAX;
    return mant_bits;
  endfunction

  function logic [31:0] max_pattern(int unsigned eb, int unsigned mb);
    return (((32'd1 << (eb - 1)) - 1) << mb) | ((32'd1 << mb) - 1);
  endfunction

  function logic [31:0] min_pattern(int unsigned eb, int unsigned mb);
    return (((32'd1 << eb) - 2) << mb) | 32'd1;
  endfunction

  function logic [31:0] ieee_of_small(logic [31:0] v, int unsigned eb, int unsigned mb);
    int unsigned mag_w;
    int unsigned biased;
    logic        sgn;
    logic        neg;
    logic [31:0] mag;
    logic [31:0] mant;
    mag_w  = eb - 1;
    sgn    = v[eb + mb];
    neg    = v[mag_w + mb];
    mag    = (v >> mb) & ((32'd1 << mag_w) - 1);
    biased = neg ? 127 - mag : 127 + mag;
    mant   = (v & ((32'd1 << mb) - 1)) << (23 - mb);
    return {sgn, 8'(biased), mant[22:0]};
  endfunction

  function logic [31:0] small_of_ieee(logic [31:0] f, int unsigned eb, int unsigned mb);
    int unsigned mag_w;
    logic [31:0] sbit;
    logic [31:0] fmag;
    logic [31:0] sgn;
    logic [31:0] mag;
    logic [31:0] packed_val;
    logic [7:0]  biased;
    logic        negx;
    mag_w = eb - 1;
    sbit  = 32'd1 << (eb + mb);
    fmag  = {1'b0, f[30:0]};
    // NaN skips the clamp; negative zero counts as non-negative
    if (fmag <= 32'h7F80_0000) begin
      sgn = (f[31] && fmag != 0) ? sbit : 32'd0;
      if (fmag >= ieee_of_small(max_pattern(eb, mb), eb, mb)) return max_pattern(eb, mb) | sgn;
      if (fmag <= ieee_of_small(min_pattern(eb, mb), eb, mb)) return min_pattern(eb, mb) | sgn;
    end
    biased = f[30:23];
    if (biased < 8'd127) begin
      negx = 1'b1;
      mag  = 127 - biased;
    end else begin
      negx = 1'b0;
      mag  = biased - 127;
    end
    packed_val = {31'd0, f[31]} << (eb + mb);
    packed_val |= (({31'd0, negx} << mag_w) | (mag & ((32'd1 << mag_w) - 1))) << mb;
    packed_val |= {9'd0, f[22:0]} >> (23 - mb);
    return packed_val;
  endfunction

  // IEEE magnitude of the clamp limit under the current format
  function logic [31:0] bound_ieee(logic upper);
    int unsigned eb;
    int unsigned mb;
    eb = eff_exp();
    mb = eff_mant();
    return ieee_of_small(upper ? max_pattern(eb, mb) : min_pattern(eb, mb), eb, mb);
  endfunction

  function logic [31:0] convert(logic req, logic [31:0] operand);
    if (req == mfpu_pkg::REQ_PACK) return small_of_ieee(operand, eff_exp(), eff_mant());
    return ieee_of_small(operand, eff_exp(), eff_mant());
  endfunction

  function void note_request(logic req, logic [31:0] operand);
    conv_expect_t item;
    item.req     = req;
    item.operand = operand;
    item.result  = convert(req, operand);
    pending_results.push_back(item);
  endfunction

  function void check_result(logic [31:0] actual);
    conv_expect_t item;
    if (pending_results.size() == 0) begin
      if (failures < 10) $display("result error: unexpected beat %h, nothing pending", actual);
      failures++;
      return;
    end
    item = pending_results.pop_front();
    if (actual !== item.result) begin
      if (failures < 10)
        $display("result error: req=%0d operand=%h expected %h got %h",
                 item.req, item.operand, item.result, actual);
      failures++;
    end
  endfunction

  function int unsigned outstanding();
    return pending_results.size();
  endfunction
endclass

module minifloat_pack_unpack_top_tb;

  localparam int unsigned RUN_LIMIT        = 500000;  // cycles, far above the slowest run
  localparam int unsigned DRAIN_CYCLES     = 8;       // margin after the pipe has emptied
  localparam int unsigned PHASES           = 14;
  localparam int unsigned RANDOM_PER_PHASE = 105;

  logic                                clk;
  logic                                rst_n;
  logic                                in_tvalid;
  logic                                in_tready;
  logic [mfpu_pkg::DATA_W-1:0]         in_tdata;    // [31:0] operand_value
  logic                                in_tuser;    // [0] req_type
  logic                                out_tvalid;
  logic                                out_tready;
  logic [mfpu_pkg::DATA_W-1:0]         out_tdata;   // [31:0] result_value
  logic                                cfg_wr_en;
  logic [mfpu_pkg::CFG_IDX_W-1:0]      cfg_index;
  logic [mfpu_pkg::CFG_DATA_W-1:0]     cfg_wdata;

  minifloat_checker chk = new();

  // Remaining beats of a no-idle stretch, one counter per side
  int unsigned in_burst_left  = 0;
  int unsigned out_burst_left = 0;

  // Fixed formats for the first phases after the reset one: legal corners, then values
  // that the block must saturate, then one legal format (written as raw register contents)
  logic [mfpu_pkg::CFG_DATA_W-1:0] fixed_exp  [9] = '{2, 8, 2, 8, 0, 15, 1, 9, 3};
  logic [mfpu_pkg::CFG_DATA_W-1:0] fixed_mant [9] = '{2, 23, 23, 2, 0, 31, 24, 1, 7};

  minifloat_pack_unpack_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Sample every handshake with the values that stood before the edge. Register writes
  // update the model's format right away; the bench only writes while the pipe is empty.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_wr_en) chk.write_reg(cfg_index, cfg_wdata);
      if (in_tvalid && in_tready) chk.note_request(in_tuser, in_tdata);
      if (out_tvalid && out_tready) chk.check_result(out_tdata);
    end
  end

  // Idle length for one beat: usually a random gap, with occasional stretches of none
  function automatic int unsigned draw_wait(inout int unsigned run_left);
    if (run_left > 0) begin
      run_left--;
      return 0;
    end
    if ($urandom_range(0, 11) == 0) begin
      run_left = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 9);
  endfunction

  // Send one request beat; hold it until the block takes it. Valid stays high into the
  // next beat when no gap is drawn.
  task automatic send_request(input logic req, input logic [31:0] operand);
    int unsigned gap;
    gap = draw_wait(in_burst_left);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= operand;
    do @(posedge clk); while (!in_tready);
  endtask

  // Write both format registers on consecutive edges
  task automatic write_format(input logic [mfpu_pkg::CFG_DATA_W-1:0] exp_val,
                              input logic [mfpu_pkg::CFG_DATA_W-1:0] mant_val);
    cfg_wr_en <= 1'b1;
    cfg_index <= mfpu_pkg::REG_EXP_BITS;
    cfg_wdata <= exp_val;
    @(posedge clk);
    cfg_index <= mfpu_pkg::REG_MANT_BITS;
    cfg_wdata <= mant_val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Drop valid and wait until every accepted beat has come back, then let the pipe settle.
  // The queue is polled on the falling edge so the monitor has already run.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (chk.outstanding() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // IEEE operand for a pack request: clamp neighborhoods, the in-range band, specials
  function automatic logic [31:0] random_float();
    int unsigned eb;
    int unsigned lo;
    int unsigned hi;
    logic [31:0] value;
    eb    = chk.eff_exp();
    lo    = 127 - ((1 << (eb - 1)) - 2);
    hi    = 127 + ((1 << (eb - 1)) - 1);
    value = $urandom();
    case ($urandom_range(0, 9))
      0, 1: ;  // arbitrary pattern
      2, 3: value = {value[31], 31'(chk.bound_ieee(1'b1) + $urandom_range(0, 8) - 4)};
      4, 5: value = {value[31], 31'(chk.bound_ieee(1'b0) + $urandom_range(0, 8) - 4)};
      6, 7, 8: value[30:23] = 8'($urandom_range(lo, hi));
      default: begin
        case ($urandom_range(0, 3))
          0: value[30:0] = 31'd0;
          1: value[30:0] = 31'h7F80_0000;
          2: begin
            value[30:23] = 8'hFF;
            value[0]     = 1'b1;  // keep it a NaN
          end
          default: value[30:23] = 8'h00;
        endcase
      end
    endcase
    return value;
  endfunction

  // Small-format operand for an unpack request, usually confined to the format's width
  function automatic logic [31:0] random_small();
    int unsigned eb;
    int unsigned mb;
    int unsigned width;
    logic [31:0] value;
    eb    = chk.eff_exp();
    mb    = chk.eff_mant();
    width = 1 + eb + mb;
    value = $urandom();
    if ($urandom_range(0, 9) < 7 && width < 32) value &= (32'd1 << width) - 1;
    // exponent field of minus zero
    if ($urandom_range(0, 7) == 0)
      value = (value & ~(((32'd1 << eb) - 1) << mb)) | ((32'd1 << (eb - 1)) << mb);
    return value;
  endfunction

  task automatic run_random(input int unsigned count);
    logic req;
    repeat (count) begin
      req = 1'($urandom_range(0, 1));
      if (req == mfpu_pkg::REQ_PACK) send_request(mfpu_pkg::REQ_PACK, random_float());
      else send_request(mfpu_pkg::REQ_UNPACK, random_small());
    end
  endtask

  // Corner beats under the reset format
  task automatic run_directed();
    logic [31:0] top;
    logic [31:0] bottom;
    int unsigned eb;
    int unsigned mb;
    top    = chk.bound_ieee(1'b1);
    bottom = chk.bound_ieee(1'b0);
    eb     = chk.eff_exp();
    mb     = chk.eff_mant();
    send_request(mfpu_pkg::REQ_PACK, 32'h0000_0000);  // zero clamps to the min pattern
    send_request(mfpu_pkg::REQ_PACK, 32'h8000_0000);  // negative zero keeps the sign clear
    send_request(mfpu_pkg::REQ_PACK, 32'h7F80_0000);  // +inf
    send_request(mfpu_pkg::REQ_PACK, 32'hFF80_0000);  // -inf
    send_request(mfpu_pkg::REQ_PACK, 32'h7FC0_0000);  // quiet NaN, unclamped path
    send_request(mfpu_pkg::REQ_PACK, 32'hFFFF_FFFF);  // negative NaN, all ones
    send_request(mfpu_pkg::REQ_PACK, 32'h7F80_0001);  // smallest NaN
    send_request(mfpu_pkg::REQ_PACK, 32'h7F7F_FFFF);  // largest finite
    send_request(mfpu_pkg::REQ_PACK, 32'h0000_0001);  // smallest denormal
    send_request(mfpu_pkg::REQ_PACK, 32'h3F80_0000);  // 1.0
    send_request(mfpu_pkg::REQ_PACK, 32'hBF80_0000);  // -1.0
    send_request(mfpu_pkg::REQ_PACK, top);            // exactly at the max clamp
    send_request(mfpu_pkg::REQ_PACK, top - 1);
    send_request(mfpu_pkg::REQ_PACK, 32'h8000_0000 | top);
    send_request(mfpu_pkg::REQ_PACK, bottom);         // exactly at the min clamp
    send_request(mfpu_pkg::REQ_PACK, bottom + 1);
    send_request(mfpu_pkg::REQ_PACK, 32'h8000_0000 | (bottom + 1));
    send_request(mfpu_pkg::REQ_UNPACK, 32'h0000_0000);
    send_request(mfpu_pkg::REQ_UNPACK, 32'hFFFF_FFFF);  // extra high bits set
    send_request(mfpu_pkg::REQ_UNPACK, ((32'd1 << (eb - 1)) << mb) | 32'd1);
    send_request(mfpu_pkg::REQ_UNPACK,
                 32'hABCD_0000 | (32'd1 << (eb + mb)) | chk.max_pattern(eb, mb));
  endtask

  // Receiver: stall for a drawn number of cycles, then take one result beat
  initial begin
    int unsigned stall;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = draw_wait(out_burst_left);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Watchdog
  initial begin
    repeat (RUN_LIMIT) @(posedge clk);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Main sequence: reset, corners and random traffic under the reset format, then one
  // phase per format with the pipe drained before each register write.
  initial begin
    logic [mfpu_pkg::CFG_DATA_W-1:0] exp_val;
    logic [mfpu_pkg::CFG_DATA_W-1:0] mant_val;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = mfpu_pkg::REQ_PACK;
    cfg_wr_en = 1'b0;
    cfg_index = mfpu_pkg::REG_EXP_BITS;
    cfg_wdata = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    run_random(RANDOM_PER_PHASE);
    for (int phase = 1; phase < PHASES; phase++) begin
      wait_idle();
      if (phase <= 9) begin
        exp_val  = fixed_exp[phase - 1];
        mant_val = fixed_mant[phase - 1];
      end else begin
        exp_val  = mfpu_pkg::CFG_DATA_W'($urandom_range(0, 31));
        mant_val = mfpu_pkg::CFG_DATA_W'($urandom_range(0, 31));
      end
      write_format(exp_val, mant_val);
      run_random(RANDOM_PER_PHASE);
    end
    wait_idle();

    if (chk.failures == 0 && chk.outstanding() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
